/* hdl/scancode_set1_decoder_fifo_unit_defines.svh */
`ifndef SCANCODE_SET1_DECODER_FIFO_UNIT_DEFINES_SVH
`define SCANCODE_SET1_DECODER_FIFO_UNIT_DEFINES_SVH

// Property checked at every rising edge of clk_i, off while rst_ni is low.
`define SCD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// A stalled item keeps its valid and the given payload signal.
`define SCD_ASSERT_HOLD(label, vld, stl, sig, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (vld && stl) |=> (vld && $stable(sig))) else $error(msg);

`endif

/* hdl/scd_pkg.sv */
`default_nettype none

package scd_pkg;

  localparam int FIFO_DEPTH  = 128;
  localparam int MAP_ENTRIES = 256;
  localparam int QUEUE_DEPTH = 2;

  localparam int PTR_W     = $clog2(FIFO_DEPTH);
  localparam int CNT_W     = $clog2(FIFO_DEPTH + 1);
  localparam int MAP_IDX_W = $clog2(MAP_ENTRIES);
  localparam int QPTR_W    = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);

  // Prefix bytes and the codes that follow an E0 prefix.
  localparam logic [7:0] CODE_E1       = 8'he1;
  localparam logic [7:0] CODE_E0       = 8'he0;
  localparam logic [7:0] CODE_CTRL     = 8'h1d;
  localparam logic [7:0] CODE_CTRL_BRK = 8'h9d;
  localparam logic [7:0] CODE_ALT      = 8'h38;
  localparam logic [7:0] CODE_ALT_BRK  = 8'hb8;

  // Key numbers with the break bit removed.
  localparam logic [6:0] KEY_SHIFT_L = 7'h2a;
  localparam logic [6:0] KEY_SHIFT_R = 7'h36;
  localparam logic [6:0] KEY_CTRL    = 7'h1d;
  localparam logic [6:0] KEY_ALT     = 7'h38;

  localparam logic [2:0] SKIP_COUNT = 3'd5;

  // Bit positions in the modifier word.
  localparam int MOD_SHIFT_L = 0;
  localparam int MOD_SHIFT_R = 1;
  localparam int MOD_CTRL_L  = 2;
  localparam int MOD_CTRL_R  = 3;
  localparam int MOD_ALT_L   = 4;
  localparam int MOD_ALT_R   = 5;

  typedef enum logic [1:0] {
    ACT_SCAN = 2'd0,
    ACT_POP  = 2'd1,
    ACT_MAP  = 2'd2,
    ACT_NOP  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    PFX_NONE = 2'd0,
    PFX_E0   = 2'd1,
    PFX_E1   = 2'd2
  } prefix_e;

  // Decoded item handed from the front to the back.
  typedef struct packed {
    action_e    act;
    logic       lookup;
    logic [7:0] key;
    logic [5:0] mods;
  } scd_item_t;

endpackage

`default_nettype wire

/* hdl/scd_front.sv */
`default_nettype none

module scd_front
  import scd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [1:0] action_i,
  input  wire logic [7:0] scan_code_i,
  input  wire logic [7:0] map_index_i,
  input  wire logic [7:0] map_value_i,
  output logic            item_valid_o,
  output scd_item_t       item_o,
  input  wire logic       item_ready_i
);

  logic [7:0] key_table [MAP_ENTRIES];

  prefix_e    pfx_q, pfx_d;
  logic [2:0] skip_q, skip_d;
  logic [5:0] mods_q, mods_d;

  logic       s1_valid_q, s1_valid_d;
  action_e    s1_act_q;
  logic       s1_lookup_q;
  logic [5:0] s1_mods_q;
  logic [7:0] s1_key_q;

  logic       accept;
  action_e    act;
  logic       is_scan;
  logic       is_prefix;
  logic       make;
  logic [6:0] low;
  logic [2:0] skip_dec;
  logic       lookup;
  logic [MAP_IDX_W-1:0] map_rd_idx;

  assign act        = action_e'(action_i);
  assign in_stall_o = s1_valid_q && !item_ready_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign is_scan    = (act == ACT_SCAN);
  assign is_prefix  = (scan_code_i == CODE_E1) || (scan_code_i == CODE_E0);
  assign make       = !scan_code_i[7];
  assign low        = scan_code_i[6:0];
  assign skip_dec   = skip_q - 3'd1;
  assign map_rd_idx = MAP_IDX_W'({low, mods_q[MOD_SHIFT_L] | mods_q[MOD_SHIFT_R]});

  // Prefix state: E1 and E0 always win over a pending prefix.
  always_comb begin
    pfx_d  = pfx_q;
    skip_d = skip_q;
    if (accept && is_scan) begin
      priority if (scan_code_i == CODE_E1) begin
        pfx_d  = PFX_E1;
        skip_d = SKIP_COUNT;
      end else if (scan_code_i == CODE_E0) begin
        pfx_d = PFX_E0;
      end else if (pfx_q == PFX_E1) begin
        skip_d = skip_dec;
        if (skip_dec == 3'd0) begin
          pfx_d = PFX_NONE;
        end
      end else begin
        pfx_d = PFX_NONE;
      end
    end
  end

  // Modifier updates and the keymap lookup decision.
  always_comb begin
    mods_d = mods_q;
    lookup = 1'b0;
    if (is_scan && !is_prefix) begin
      unique case (pfx_q)
        PFX_E1: begin
        end
        PFX_E0: begin
          priority if (scan_code_i == CODE_CTRL) begin
            mods_d[MOD_CTRL_R] = 1'b1;
          end else if (scan_code_i == CODE_CTRL_BRK) begin
            mods_d[MOD_CTRL_R] = 1'b0;
          end else if (scan_code_i == CODE_ALT) begin
            mods_d[MOD_ALT_R] = 1'b1;
          end else if (scan_code_i == CODE_ALT_BRK) begin
            mods_d[MOD_ALT_R] = 1'b0;
          end else begin
            // Any other byte after E0 only consumes the prefix.
          end
        end
        default: begin
          priority if (low == KEY_SHIFT_L) begin
            mods_d[MOD_SHIFT_L] = make;
          end else if (low == KEY_SHIFT_R) begin
            mods_d[MOD_SHIFT_R] = make;
          end else if (low == KEY_CTRL) begin
            mods_d[MOD_CTRL_L] = make;
          end else if (low == KEY_ALT) begin
            mods_d[MOD_ALT_L] = make;
          end else begin
            lookup = make;
          end
        end
      endcase
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (item_ready_i) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pfx_q      <= PFX_NONE;
      skip_q     <= 3'd0;
      mods_q     <= 6'd0;
      s1_valid_q <= 1'b0;
    end else begin
      pfx_q      <= pfx_d;
      skip_q     <= skip_d;
      s1_valid_q <= s1_valid_d;
      if (accept) begin
        mods_q <= mods_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_act_q    <= act;
      s1_lookup_q <= lookup;
      s1_mods_q   <= mods_d;
    end
  end

  // Keymap: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (accept && (act == ACT_MAP)) begin
      key_table[MAP_IDX_W'(map_index_i)] <= map_value_i;
    end
    if (accept) begin
      s1_key_q <= key_table[map_rd_idx];
    end
  end

  assign item_valid_o  = s1_valid_q;
  assign item_o.act    = s1_act_q;
  assign item_o.lookup = s1_lookup_q;
  assign item_o.key    = s1_key_q;
  assign item_o.mods   = s1_mods_q;

endmodule

`default_nettype wire

/* hdl/scd_queue.sv */
`default_nettype none

module scd_queue
  import scd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire scd_item_t  push_item_i,
  output logic            ready_o,
  output logic            valid_o,
  output scd_item_t       item_o,
  input  wire logic       pop_i
);

  scd_item_t entry_q [QUEUE_DEPTH];

  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              do_push;
  logic              do_pop;

  assign ready_o = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

/* hdl/scd_back.sv */
`default_nettype none

module scd_back
  import scd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       item_valid_i,
  input  wire scd_item_t  item_i,
  output logic            item_pop_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic            char_valid_o,
  output logic [7:0]      char_value_o,
  output logic            char_queued_o,
  output logic            char_dropped_o,
  output logic [7:0]      fill_level_o,
  output logic [5:0]      modifier_flags_o
);

  logic [7:0] char_store [FIFO_DEPTH];

  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             out_valid_q, out_valid_d;

  logic       char_valid_q;
  logic [7:0] char_data_q;
  logic       queued_q;
  logic       dropped_q;
  logic [7:0] fill_q;
  logic [5:0] mods_q;

  logic go;
  logic has_char;
  logic full;
  logic push;
  logic drop;
  logic pop;

  assign go       = item_valid_i && (!out_valid_q || !out_stall_i);
  assign has_char = (item_i.act == ACT_SCAN) && item_i.lookup && (item_i.key != 8'd0);
  assign full     = (count_q == CNT_W'(FIFO_DEPTH));
  assign push     = go && has_char && !full;
  assign drop     = go && has_char && full;
  assign pop      = go && (item_i.act == ACT_POP) && (count_q != '0);

  assign item_pop_o = go;

  always_comb begin
    rd_ptr_d = rd_ptr_q;
    wr_ptr_d = wr_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      count_d  = count_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      count_d  = count_q - 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (go) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q    <= '0;
      wr_ptr_q    <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rd_ptr_q    <= rd_ptr_d;
      wr_ptr_q    <= wr_ptr_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Character storage; the read data lands straight in the output register.
  always_ff @(posedge clk_i) begin
    if (push) begin
      char_store[wr_ptr_q] <= item_i.key;
    end
    if (pop) begin
      char_data_q <= char_store[rd_ptr_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      char_valid_q <= pop;
      queued_q     <= push;
      dropped_q    <= drop;
      fill_q       <= 8'(count_d);
      mods_q       <= item_i.mods;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign char_valid_o     = char_valid_q;
  assign char_value_o     = char_valid_q ? char_data_q : 8'd0;
  assign char_queued_o    = queued_q;
  assign char_dropped_o   = dropped_q;
  assign fill_level_o     = fill_q;
  assign modifier_flags_o = mods_q;

endmodule

`default_nettype wire

/* hdl/scancode_set1_decoder_fifo_unit.sv */
// Path: the front registers an accepted item, the queue stores it, the back registers the result.
// Throughput: one item per cycle unless stalled; the front decodes and reads the keymap, the back
// owns the character storage, and a two-entry queue between them lets each side stall on its own.
// Reset: asynchronous, active low; clears prefix, modifiers, pointers and counts. The keymap
// and the character storage keep their contents and are not cleared.
`default_nettype none

module scancode_set1_decoder_fifo_unit
  import scd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [1:0] action_i,
  input  wire logic [7:0] scan_code_i,
  input  wire logic [7:0] map_index_i,
  input  wire logic [7:0] map_value_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic            char_valid_o,
  output logic [7:0]      char_value_o,
  output logic            char_queued_o,
  output logic            char_dropped_o,
  output logic [7:0]      fill_level_o,
  output logic [5:0]      modifier_flags_o
);

  logic      front_valid;
  scd_item_t front_item;
  logic      queue_ready;
  logic      queue_valid;
  scd_item_t queue_item;
  logic      queue_pop;

  scd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .scan_code_i  (scan_code_i),
    .map_index_i  (map_index_i),
    .map_value_i  (map_value_i),
    .item_valid_o (front_valid),
    .item_o       (front_item),
    .item_ready_i (queue_ready)
  );

  scd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (front_valid),
    .push_item_i (front_item),
    .ready_o     (queue_ready),
    .valid_o     (queue_valid),
    .item_o      (queue_item),
    .pop_i       (queue_pop)
  );

  scd_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .item_valid_i     (queue_valid),
    .item_i           (queue_item),
    .item_pop_o       (queue_pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .char_valid_o     (char_valid_o),
    .char_value_o     (char_value_o),
    .char_queued_o    (char_queued_o),
    .char_dropped_o   (char_dropped_o),
    .fill_level_o     (fill_level_o),
    .modifier_flags_o (modifier_flags_o)
  );

endmodule

`default_nettype wire

/* hdl/scd_checker.sv */
`default_nettype none
`include "scancode_set1_decoder_fifo_unit_defines.svh"

module scd_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic [1:0] action_i,
  input wire logic [7:0] scan_code_i,
  input wire logic [7:0] map_index_i,
  input wire logic [7:0] map_value_i,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic       char_valid_o,
  input wire logic [7:0] char_value_o,
  input wire logic       char_queued_o,
  input wire logic       char_dropped_o,
  input wire logic [7:0] fill_level_o,
  input wire logic [5:0] modifier_flags_o
);

  logic [25:0] in_payload;
  logic [24:0] out_payload;

  assign in_payload  = {action_i, scan_code_i, map_index_i, map_value_i};
  assign out_payload = {char_valid_o, char_value_o, char_queued_o, char_dropped_o,
                        fill_level_o, modifier_flags_o};

  // A stalled input item keeps its valid and its fields.
  `SCD_ASSERT_HOLD(a_in_hold, in_valid_i, in_stall_o, in_payload, "stalled input item changed")

  // A stalled result keeps all of its fields.
  `SCD_ASSERT_HOLD(a_out_hold, out_valid_o, out_stall_i, out_payload, "stalled result changed")

  // A pop never reports a push or a drop in the same item.
  `SCD_ASSERT(a_pop_excl, (out_valid_o && char_valid_o) |-> !(char_queued_o || char_dropped_o), "pop flagged as push")

  `SCD_ASSERT(a_push_excl, out_valid_o |-> !(char_queued_o && char_dropped_o), "queued and dropped together")

  // Only nonzero characters are ever stored.
  `SCD_ASSERT(a_char_val, (out_valid_o && char_valid_o) |-> (char_value_o != 8'd0), "zero character popped")

endmodule

bind scancode_set1_decoder_fifo_unit scd_checker u_scd_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .action_i         (action_i),
  .scan_code_i      (scan_code_i),
  .map_index_i      (map_index_i),
  .map_value_i      (map_value_i),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .char_valid_o     (char_valid_o),
  .char_value_o     (char_value_o),
  .char_queued_o    (char_queued_o),
  .char_dropped_o   (char_dropped_o),
  .fill_level_o     (fill_level_o),
  .modifier_flags_o (modifier_flags_o)
);

`default_nettype wire

/* dv/tb_scancode_set1_decoder_fifo_unit.sv */
`timescale 1ns / 100ps

module tb_scancode_set1_decoder_fifo_unit;
  import scd_pkg::*;

  localparam int STUCK_LIMIT = 4000;
  localparam int PHASE_ITEMS = 300;
  localparam int IDLE_PCT [4] = '{0, 57, 0, 6};
  localparam int STALL_PCT [4] = '{0, 0, 57, 6};

  typedef enum int {
    PUSH_NONE,
    PUSH_QUEUED,
    PUSH_DROPPED
  } push_e;

  typedef struct packed {
    logic       char_valid;
    logic [7:0] char_value;
    logic       char_queued;
    logic       char_dropped;
    logic [7:0] fill_level;
    logic [5:0] modifier_flags;
  } char_result_t;

  // Tracks decoder and FIFO state and predicts the status of every item.
  class scancode_char_model;
    prefix_e      mode;
    logic [2:0]   skip;
    logic [5:0]   mods;
    logic [7:0]   keymap [MAP_ENTRIES];
    bit           written [MAP_ENTRIES];
    logic [7:0]   chars [FIFO_DEPTH];
    int           rd;
    int           wr;
    int           held;
    int           errors;
    char_result_t expected_chars_q [$];

    function new();
      mode   = PFX_NONE;
      skip   = '0;
      mods   = '0;
      rd     = 0;
      wr     = 0;
      held   = 0;
      errors = 0;
      foreach (written[i]) written[i] = 1'b0;
    endfunction

    // True when this byte would look up a keymap entry that was never written.
    function bit needs_map(logic [7:0] code, output logic [7:0] slot);
      slot = {code[6:0], mods[MOD_SHIFT_L] | mods[MOD_SHIFT_R]};
      if (code == CODE_E1 || code == CODE_E0 || mode != PFX_NONE || code[7]) return 1'b0;
      if (code[6:0] inside {KEY_SHIFT_L, KEY_SHIFT_R, KEY_CTRL, KEY_ALT}) return 1'b0;
      return !written[slot];
    endfunction

    function push_e decode_scan_byte(logic [7:0] code);
      logic       make;
      logic [6:0] key;
      logic [7:0] ch;
      if (code == CODE_E1) begin
        mode = PFX_E1;
        skip = SKIP_COUNT;
        return PUSH_NONE;
      end
      if (code == CODE_E0) begin
        mode = PFX_E0;
        return PUSH_NONE;
      end
      if (mode == PFX_E1) begin
        skip = skip - 3'd1;
        if (skip == 3'd0) mode = PFX_NONE;
        return PUSH_NONE;
      end
      if (mode == PFX_E0) begin
        case (code)
          CODE_CTRL:     mods[MOD_CTRL_R] = 1'b1;
          CODE_CTRL_BRK: mods[MOD_CTRL_R] = 1'b0;
          CODE_ALT:      mods[MOD_ALT_R] = 1'b1;
          CODE_ALT_BRK:  mods[MOD_ALT_R] = 1'b0;
          default: ;
        endcase
        mode = PFX_NONE;
        return PUSH_NONE;
      end
      mode = PFX_NONE;
      make = !code[7];
      key  = code[6:0];
      if (key == KEY_SHIFT_L) begin
        mods[MOD_SHIFT_L] = make;
      end else if (key == KEY_SHIFT_R) begin
        mods[MOD_SHIFT_R] = make;
      end else if (key == KEY_CTRL) begin
        mods[MOD_CTRL_L] = make;
      end else if (key == KEY_ALT) begin
        mods[MOD_ALT_L] = make;
      end else if (make) begin
        ch = keymap[{key, mods[MOD_SHIFT_L] | mods[MOD_SHIFT_R]}];
        if (ch == 8'd0) return PUSH_NONE;
        if (held >= FIFO_DEPTH) return PUSH_DROPPED;
        chars[wr] = ch;
        wr = (wr + 1) % FIFO_DEPTH;
        held++;
        return PUSH_QUEUED;
      end
      return PUSH_NONE;
    endfunction

    function void note_item(action_e act, logic [7:0] code, logic [7:0] idx,
                            logic [7:0] val);
      char_result_t r;
      push_e        p;
      r = '0;
      case (act)
        ACT_SCAN: begin
          p = decode_scan_byte(code);
          r.char_queued  = (p == PUSH_QUEUED);
          r.char_dropped = (p == PUSH_DROPPED);
        end
        ACT_POP: begin
          if (held > 0) begin
            r.char_valid = 1'b1;
            r.char_value = chars[rd];
            rd = (rd + 1) % FIFO_DEPTH;
            held--;
          end
        end
        ACT_MAP: begin
          keymap[idx]  = val;
          written[idx] = 1'b1;
        end
        default: ;
      endcase
      r.fill_level     = 8'(held);
      r.modifier_flags = mods;
      expected_chars_q.push_back(r);
    endfunction

    function void compare(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(char_result_t got);
      char_result_t want;
      if (expected_chars_q.size() == 0) begin
        $error("result arrived with no item outstanding");
        errors++;
        return;
      end
      want = expected_chars_q.pop_front();
      compare("char_valid", 8'(want.char_valid), 8'(got.char_valid));
      compare("char_value", want.char_value, got.char_value);
      compare("char_queued", 8'(want.char_queued), 8'(got.char_queued));
      compare("char_dropped", 8'(want.char_dropped), 8'(got.char_dropped));
      compare("fill_level", want.fill_level, got.fill_level);
      compare("modifier_flags", 8'(want.modifier_flags), 8'(got.modifier_flags));
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [1:0] action_i = ACT_NOP;
  logic [7:0] scan_code_i = '0;
  logic [7:0] map_index_i = '0;
  logic [7:0] map_value_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic       char_valid_o;
  logic [7:0] char_value_o;
  logic       char_queued_o;
  logic       char_dropped_o;
  logic [7:0] fill_level_o;
  logic [5:0] modifier_flags_o;

  int in_idle_pct = 0;
  int out_stall_pct = 0;
  int items_sent = 0;
  int stuck_cycles = 0;
  scancode_char_model model;

  scancode_set1_decoder_fifo_unit u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .action_i         (action_i),
    .scan_code_i      (scan_code_i),
    .map_index_i      (map_index_i),
    .map_value_i      (map_value_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .char_valid_o     (char_valid_o),
    .char_value_o     (char_value_o),
    .char_queued_o    (char_queued_o),
    .char_dropped_o   (char_dropped_o),
    .fill_level_o     (fill_level_o),
    .modifier_flags_o (modifier_flags_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < out_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      model.check_result('{char_valid_o, char_value_o, char_queued_o, char_dropped_o,
                           fill_level_o, modifier_flags_o});
    end
  end

  initial begin
    while (stuck_cycles < STUCK_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
      end
    end
    $display("tb_scancode_set1_decoder_fifo_unit: done, errors");
    $finish;
  end

  function automatic logic [7:0] pick_char();
    return ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
  endfunction

  // Valid stays high from one item to the next unless a gap is taken.
  task automatic send_item(action_e act, logic [7:0] code, logic [7:0] idx,
                           logic [7:0] val);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    action_i    <= act;
    scan_code_i <= code;
    map_index_i <= idx;
    map_value_i <= val;
    do @(posedge clk_i); while (in_stall_o);
    model.note_item(act, code, idx, val);
    if (act != ACT_NOP) items_sent++;
  endtask

  // Writes the keymap entry first when the byte would read one never written.
  task automatic send_scan(logic [7:0] code);
    logic [7:0] slot;
    if (model.needs_map(code, slot)) begin
      send_item(ACT_MAP, 8'($urandom_range(255)), slot, pick_char());
    end
    send_item(ACT_SCAN, code, 8'($urandom_range(255)), 8'($urandom_range(255)));
  endtask

  task automatic send_pop();
    send_item(ACT_POP, 8'($urandom_range(255)), 8'($urandom_range(255)),
              8'($urandom_range(255)));
  endtask

  task automatic type_key();
    logic [6:0] key;
    do key = 7'($urandom_range(127));
    while (key inside {KEY_SHIFT_L, KEY_SHIFT_R, KEY_CTRL, KEY_ALT});
    send_scan({1'b0, key});
    if ($urandom_range(1)) send_scan({1'b1, key});
  endtask

  // Fills the FIFO past full so that characters drop, then empties it.
  task automatic flood_and_drain();
    while (model.held < FIFO_DEPTH) type_key();
    repeat (6) type_key();
    while (model.held > 0) send_pop();
    send_pop();
  endtask

  task automatic random_burst();
    logic [6:0] shift_key;
    int         n;
    int         pick;
    pick = $urandom_range(99);
    if (pick < 30) begin
      repeat ($urandom_range(1, 8)) type_key();
    end else if (pick < 40) begin
      shift_key = $urandom_range(1) ? KEY_SHIFT_L : KEY_SHIFT_R;
      send_scan({1'b0, shift_key});
      repeat ($urandom_range(1, 4)) type_key();
      if ($urandom_range(4) != 0) send_scan({1'b1, shift_key});
    end else if (pick < 52) begin
      send_scan(CODE_E0);
      case ($urandom_range(4))
        0: send_scan(CODE_CTRL);
        1: send_scan(CODE_CTRL_BRK);
        2: send_scan(CODE_ALT);
        3: send_scan(CODE_ALT_BRK);
        default: send_scan(8'($urandom_range(255)));
      endcase
    end else if (pick < 58) begin
      // Mostly a complete six-byte sequence; sometimes cut short or overlong.
      n = ($urandom_range(3) == 0) ? $urandom_range(0, 6) : 5;
      send_scan(CODE_E1);
      repeat (n) send_scan(8'($urandom_range(255)));
    end else if (pick < 68) begin
      send_scan({$urandom_range(1) == 1, $urandom_range(1) ? KEY_CTRL : KEY_ALT});
    end else if (pick < 84) begin
      repeat ($urandom_range(1, 10)) send_pop();
    end else if (pick < 91) begin
      repeat ($urandom_range(1, 3)) begin
        send_item(ACT_MAP, 8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)));
      end
    end else if (pick < 95) begin
      send_item(ACT_NOP, 8'($urandom_range(255)), 8'($urandom_range(255)),
                8'($urandom_range(255)));
    end else begin
      send_scan(8'($urandom_range(255)));
    end
  endtask

  initial begin
    model = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_pop();
    send_item(ACT_NOP, 8'hff, 8'hff, 8'hff);
    send_item(ACT_MAP, 8'h00, 8'h00, 8'hff);
    send_item(ACT_MAP, 8'h00, 8'hff, 8'h01);
    send_item(ACT_MAP, 8'h00, 8'h3c, 8'h61);
    send_item(ACT_MAP, 8'h00, 8'h3d, 8'h41);
    send_item(ACT_MAP, 8'h00, 8'h04, 8'h00);
    send_scan(8'h00);
    send_scan({1'b0, KEY_SHIFT_L});
    send_scan(8'h1e);
    send_scan({1'b0, KEY_SHIFT_R});
    send_scan({1'b1, KEY_SHIFT_L});
    send_scan(8'h7f);
    send_scan({1'b1, KEY_SHIFT_R});
    // A written entry of zero yields no character, and neither does a break.
    send_scan(8'h02);
    send_scan(8'h9e);
    send_scan({1'b0, KEY_CTRL});
    send_scan(CODE_E0);
    send_scan(CODE_ALT);
    send_scan(CODE_E0);
    send_scan(8'h48);
    // A second E1 restarts the skip, and an E0 cancels it.
    send_scan(CODE_E1);
    send_scan(8'h45);
    send_scan(CODE_E1);
    send_scan(CODE_E0);
    send_scan(CODE_CTRL);
    send_pop();

    for (int p = 0; p < 4; p++) begin
      in_idle_pct   = IDLE_PCT[p];
      out_stall_pct = STALL_PCT[p];
      if (p == 2) flood_and_drain();
      while (items_sent < (p + 1) * PHASE_ITEMS) random_burst();
    end
    in_valid_i <= 1'b0;

    while (model.expected_chars_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (model.errors == 0) begin
      $display("tb_scancode_set1_decoder_fifo_unit: done, clean");
    end else begin
      $display("tb_scancode_set1_decoder_fifo_unit: done, errors");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/scd_pkg.sv
hdl/scd_front.sv
hdl/scd_queue.sv
hdl/scd_back.sv
hdl/scancode_set1_decoder_fifo_unit.sv
hdl/scd_checker.sv
dv/tb_scancode_set1_decoder_fifo_unit.sv
